>>> rtl/hfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfu_pkg: shared types, codes and decode tables
// Opcode and funct codes of the five-stage pipeline, the request and result
// payloads, and the small decode tables used by the hazard and forward logic.
// ----------------------------------------------------------------------------
package hfu_pkg;

  localparam int unsigned InstrW = 32;
  localparam int unsigned RegW   = 5;
  localparam int unsigned CodeW  = 6;

  typedef logic [RegW-1:0]  reg_num_t;
  typedef logic [CodeW-1:0] code_t;

  // Opcodes
  localparam code_t OP_RTYPE = 6'h00;
  localparam code_t OP_J     = 6'h02;
  localparam code_t OP_JAL   = 6'h03;
  localparam code_t OP_BEQ   = 6'h04;
  localparam code_t OP_BNE   = 6'h05;
  localparam code_t OP_BGTZ  = 6'h07;
  localparam code_t OP_ADDI  = 6'h08;
  localparam code_t OP_ADDIU = 6'h09;
  localparam code_t OP_SLTI  = 6'h0a;
  localparam code_t OP_ANDI  = 6'h0c;
  localparam code_t OP_ORI   = 6'h0d;
  localparam code_t OP_XORI  = 6'h0e;
  localparam code_t OP_LUI   = 6'h0f;
  localparam code_t OP_LB    = 6'h20;
  localparam code_t OP_LH    = 6'h21;
  localparam code_t OP_LW    = 6'h23;
  localparam code_t OP_LBU   = 6'h24;
  localparam code_t OP_LHU   = 6'h25;
  localparam code_t OP_SB    = 6'h28;
  localparam code_t OP_SH    = 6'h29;
  localparam code_t OP_SW    = 6'h2b;

  // R-type funct codes
  localparam code_t FN_SLL   = 6'h00;
  localparam code_t FN_SRL   = 6'h02;
  localparam code_t FN_SRA   = 6'h03;
  localparam code_t FN_JR    = 6'h08;
  localparam code_t FN_MULT  = 6'h18;
  localparam code_t FN_MULTU = 6'h19;
  localparam code_t FN_ADD   = 6'h20;
  localparam code_t FN_ADDU  = 6'h21;
  localparam code_t FN_SUB   = 6'h22;
  localparam code_t FN_AND   = 6'h24;
  localparam code_t FN_OR    = 6'h25;
  localparam code_t FN_XOR   = 6'h26;
  localparam code_t FN_NOR   = 6'h27;
  localparam code_t FN_ALU28 = 6'h28;
  localparam code_t FN_SLT   = 6'h2a;

  // Pipeline snapshot, one per request
  typedef struct packed {
    logic [InstrW-1:0] decode_instr;
    reg_num_t          idex_load_dest;
    reg_num_t          idex_wb_dest;
    logic              idex_is_rtype;
    code_t             idex_code;
    reg_num_t          idex_rs;
    reg_num_t          idex_rt;
    reg_num_t          exmem_wb_dest;
    reg_num_t          memwb_wb_dest;
    logic              memwb_word_byte_half;
    logic              memwb_is_load;
  } hfu_snap_t;

  // Result of one request
  typedef struct packed {
    logic stall_now;
    logic fwd_exmem_rs;
    logic fwd_memwb_rs;
    logic fwd_exmem_rt;
    logic fwd_memwb_rt;
    logic branch_fwd_rs;
    logic branch_fwd_rt;
  } hfu_verdict_t;

  // Hazard unit to top: stall and decode-stage branch forwards
  typedef struct packed {
    logic stall;
    logic br_rs;
    logic br_rt;
  } hfu_hazard_t;

  // Forward unit to top: execute operand selects
  typedef struct packed {
    logic em_rs;
    logic mw_rs;
    logic em_rt;
    logic mw_rt;
  } hfu_exfwd_t;

  // R-type ops that read both rs and rt
  function automatic logic r_alu(input code_t f);
    case (f) inside
      FN_ADD, FN_ADDU, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_ALU28,
      FN_SLT, FN_MULT, FN_MULTU: r_alu = 1'b1;
      default:                   r_alu = 1'b0;
    endcase
  endfunction

  // Shifts read rt only
  function automatic logic r_shift(input code_t f);
    case (f) inside
      FN_SLL, FN_SRL, FN_SRA: r_shift = 1'b1;
      default:                r_shift = 1'b0;
    endcase
  endfunction

  // I-type ops that read rs
  function automatic logic i_uses_rs(input code_t op);
    case (op) inside
      OP_ADDI, OP_ADDIU, OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH,
      OP_SB, OP_ANDI, OP_ORI, OP_XORI, OP_SLTI: i_uses_rs = 1'b1;
      default:                                  i_uses_rs = 1'b0;
    endcase
  endfunction

  // Stores read rt as data
  function automatic logic i_store(input code_t op);
    case (op) inside
      OP_SW, OP_SH, OP_SB: i_store = 1'b1;
      default:             i_store = 1'b0;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> rtl/hfu_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfu_chan_if: request and result channels
// Valid/ready channels carrying the pipeline snapshot and the hazard result.
// ----------------------------------------------------------------------------
interface hfu_snap_if import hfu_pkg::*; ();
  logic      valid;
  logic      ready;
  hfu_snap_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface hfu_verdict_if import hfu_pkg::*; ();
  logic         valid;
  logic         ready;
  hfu_verdict_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/hfu_hazard.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfu_hazard: decode-stage stall and branch forward logic
// Decodes the IF/ID instruction and checks it against the load in ID/EX,
// the ID/EX writeback and the MEM/WB writeback, and its branch operands against EX/MEM.
// ----------------------------------------------------------------------------
module hfu_hazard import hfu_pkg::*; (
  input  hfu_snap_t   snap,
  output hfu_hazard_t hazard
);

  code_t    op;
  code_t    fn;
  reg_num_t rs;
  reg_num_t rt;
  logic     lu_rs;
  logic     lu_rt;
  logic     br_st;
  logic     jr_st;
  logic     em_rs_hit;
  logic     em_rt_hit;
  logic     mw_rs_hit;
  logic     mw_rt_hit;
  logic     stall;

  // Instruction fields
  assign op = snap.decode_instr[31:26];
  assign rs = snap.decode_instr[25:21];
  assign rt = snap.decode_instr[20:16];
  assign fn = snap.decode_instr[5:0];

  // Load-use against ID/EX load
  assign lu_rs = (rs != '0) && (snap.idex_load_dest == rs);
  assign lu_rt = (rt != '0) && (snap.idex_load_dest == rt);

  // Branch waits: ID/EX result, or a memory access still in writeback
  assign em_rs_hit = (snap.idex_wb_dest != '0) && (snap.idex_wb_dest == rs);
  assign em_rt_hit = (snap.idex_wb_dest != '0) && (snap.idex_wb_dest == rt);
  assign mw_rs_hit = (snap.memwb_wb_dest != '0) && (snap.memwb_wb_dest == rs);
  assign mw_rt_hit = (snap.memwb_wb_dest != '0) && (snap.memwb_wb_dest == rt);

  assign br_st = em_rs_hit || em_rt_hit ||
                 ((mw_rs_hit || mw_rt_hit) && snap.memwb_word_byte_half);
  assign jr_st = em_rs_hit ||
                 (mw_rs_hit && snap.memwb_is_load && snap.memwb_word_byte_half);

  // Stall select by instruction class
  always_comb begin
    stall = 1'b0;
    if (op == OP_RTYPE) begin
      if (r_alu(fn)) begin
        stall = lu_rs || lu_rt;
      end else if (r_shift(fn)) begin
        stall = lu_rt;
      end else if (fn == FN_JR) begin
        stall = jr_st;
      end
    end else if (op == OP_BEQ || op == OP_BNE) begin
      stall = br_st;
    end else if (op == OP_BGTZ) begin
      stall = jr_st;
    end else if (i_store(op)) begin
      stall = lu_rs || lu_rt;
    end else if (op != OP_LUI && op != OP_J && op != OP_JAL) begin
      stall = lu_rs;
    end
  end

  // Branch compare forwards from EX/MEM, not gated by stall
  assign hazard.stall = stall;
  assign hazard.br_rs = (op == OP_BEQ || op == OP_BNE || op == OP_BGTZ ||
                         (op == OP_RTYPE && fn == FN_JR)) &&
                        (snap.exmem_wb_dest != '0) && (snap.exmem_wb_dest == rs);
  assign hazard.br_rt = (op == OP_BEQ || op == OP_BNE) &&
                        (snap.exmem_wb_dest != '0) && (snap.exmem_wb_dest == rt);

endmodule
`default_nettype wire

>>> rtl/hfu_exfwd.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfu_exfwd: execute-stage operand forward selects
// EX/MEM has priority over MEM/WB; all selects drop while stalling.
// ----------------------------------------------------------------------------
module hfu_exfwd import hfu_pkg::*; (
  input  hfu_snap_t  snap,
  input  logic       stall,
  output hfu_exfwd_t exfwd
);

  logic use_rs;
  logic use_rt;
  logic em_rs;
  logic em_rt;
  logic mw_rs;
  logic mw_rt;

  // Which operands the ID/EX instruction actually reads
  assign use_rs = snap.idex_is_rtype ? r_alu(snap.idex_code) : i_uses_rs(snap.idex_code);
  assign use_rt = snap.idex_is_rtype ? (r_alu(snap.idex_code) || r_shift(snap.idex_code))
                                     : i_store(snap.idex_code);

  // Destination matches, EX/MEM first
  assign em_rs = (snap.exmem_wb_dest != '0) && (snap.exmem_wb_dest == snap.idex_rs);
  assign em_rt = (snap.exmem_wb_dest != '0) && (snap.exmem_wb_dest == snap.idex_rt);
  assign mw_rs = (snap.memwb_wb_dest != '0) && (snap.memwb_wb_dest == snap.idex_rs) && !em_rs;
  assign mw_rt = (snap.memwb_wb_dest != '0) && (snap.memwb_wb_dest == snap.idex_rt) && !em_rt;

  assign exfwd.em_rs = !stall && use_rs && em_rs;
  assign exfwd.mw_rs = !stall && use_rs && mw_rs;
  assign exfwd.em_rt = !stall && use_rt && em_rt;
  assign exfwd.mw_rt = !stall && use_rt && mw_rt;

endmodule
`default_nettype wire

>>> rtl/pipeline_hazard_forward_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pipeline_hazard_forward_unit: hazard detection and forwarding
// Registers a pipeline snapshot, evaluates stall and forward selects, and
// holds the result in an output register.
//
//   channel   dir   payload          handshake
//   snap      in    hfu_snap_t       valid/ready
//   verdict   out   hfu_verdict_t    valid/ready
//
// A request passes through the input register, then the result register.
// One request per cycle is sustained; both registers advance
// together when the result register is empty or being taken.
// A stall on verdict backs up through the two stages into snap.ready.
// rst (synchronous) empties both stages; no state survives a request.
// ----------------------------------------------------------------------------
module pipeline_hazard_forward_unit import hfu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  hfu_snap_if.sink             snap,
  hfu_verdict_if.source        verdict
);

  logic         s1_valid;
  hfu_snap_t    s1_snap;
  logic         out_valid;
  hfu_verdict_t out_data;
  logic         s1_move;
  logic         in_take;
  hfu_hazard_t  hazard;
  hfu_exfwd_t   exfwd;
  hfu_verdict_t verdict_next;

  // Pipeline advance
  assign s1_move = s1_valid && (!out_valid || verdict.ready);
  assign snap.ready = !s1_valid || s1_move;
  assign in_take = snap.valid && snap.ready;

  // Evaluation between the two registers
  hfu_hazard u_hazard (
    .snap   (s1_snap),
    .hazard (hazard)
  );

  hfu_exfwd u_exfwd (
    .snap  (s1_snap),
    .stall (hazard.stall),
    .exfwd (exfwd)
  );

  always_comb begin
    verdict_next.stall_now     = hazard.stall;
    verdict_next.fwd_exmem_rs  = exfwd.em_rs;
    verdict_next.fwd_memwb_rs  = exfwd.mw_rs;
    verdict_next.fwd_exmem_rt  = exfwd.em_rt;
    verdict_next.fwd_memwb_rt  = exfwd.mw_rt;
    verdict_next.branch_fwd_rs = hazard.br_rs;
    verdict_next.branch_fwd_rt = hazard.br_rt;
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (snap.ready) begin
      s1_valid <= snap.valid;
    end
    if (in_take) begin
      s1_snap <= snap.data;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_move) begin
      out_data <= verdict_next;
    end
  end

  assign verdict.valid = out_valid;
  assign verdict.data  = out_data;

  // A request taken lands in the input stage
  a_take_lands: assert property (@(posedge clk) disable iff (rst)
    in_take |=> s1_valid)
    else $error("request taken but input stage empty");

  // An advancing stage fills the result register
  a_move_fills: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("stage advanced but result register empty");

  // Stall suppresses every execute forward
  a_stall_gates: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.stall_now) |->
      !(out_data.fwd_exmem_rs || out_data.fwd_memwb_rs ||
        out_data.fwd_exmem_rt || out_data.fwd_memwb_rt))
    else $error("execute forward set while stalling");

  // EX/MEM and MEM/WB never both selected for one operand
  a_one_src: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.fwd_exmem_rs && out_data.fwd_memwb_rs) &&
                  !(out_data.fwd_exmem_rt && out_data.fwd_memwb_rt))
    else $error("two forward sources selected");

endmodule
`default_nettype wire

>>> tb/hfu_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfu_verdict_checker: result predictor and comparator for the hazard unit
// Watches the snapshot and verdict channels. Every accepted request gets its
// stall and forward selects predicted from the snapshot alone. Every accepted
// result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module hfu_verdict_checker import hfu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  hfu_snap_if     snap,
  hfu_verdict_if  verdict,
  output int      fail_count,
  output int      pending,
  output int      checked,
  output int      stalls_seen,
  output int      forwards_seen
);

  hfu_verdict_t expected_verdicts[$];
  int n_fail    = 0;
  int n_checked = 0;
  int n_stall   = 0;
  int n_fwd     = 0;
  int n_pending = 0;

  assign fail_count    = n_fail;
  assign pending       = n_pending;
  assign checked       = n_checked;
  assign stalls_seen   = n_stall;
  assign forwards_seen = n_fwd;

  // R-type functs that read rs and rt
  function automatic logic reads_both_funct(code_t f);
    case (f)
      FN_ADD, FN_ADDU, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_ALU28,
      FN_SLT, FN_MULT, FN_MULTU: return 1'b1;
      default:                   return 1'b0;
    endcase
  endfunction

  function automatic logic shift_funct(code_t f);
    return f == FN_SLL || f == FN_SRL || f == FN_SRA;
  endfunction

  // I-type opcodes whose rs is an operand
  function automatic logic imm_reads_rs(code_t op);
    case (op)
      OP_ADDI, OP_ADDIU, OP_LW, OP_LH, OP_LB, OP_LBU, OP_LHU, OP_SW, OP_SH,
      OP_SB, OP_ANDI, OP_ORI, OP_XORI, OP_SLTI: return 1'b1;
      default:                                  return 1'b0;
    endcase
  endfunction

  function automatic logic store_op(code_t op);
    return op == OP_SW || op == OP_SH || op == OP_SB;
  endfunction

  // Stall and forward selects for one pipeline snapshot
  function automatic hfu_verdict_t predict_verdict(hfu_snap_t s);
    code_t        op, fn;
    reg_num_t     rs, rt;
    logic         ld_rs, ld_rt, br_wait, jr_wait, stall;
    logic         rd_rs, rd_rt, em_rs, em_rt, mw_rs, mw_rt;
    hfu_verdict_t v;
    op = s.decode_instr[31:26];
    rs = s.decode_instr[25:21];
    rt = s.decode_instr[20:16];
    fn = s.decode_instr[5:0];

    ld_rs   = rs != '0 && s.idex_load_dest == rs;
    ld_rt   = rt != '0 && s.idex_load_dest == rt;
    // beq/bne wait on an ID/EX result or any matching memory access in writeback
    br_wait = (s.idex_wb_dest != '0 && (s.idex_wb_dest == rs || s.idex_wb_dest == rt)) ||
              (s.memwb_wb_dest != '0 && (s.memwb_wb_dest == rs || s.memwb_wb_dest == rt) &&
               s.memwb_word_byte_half);
    // jr/bgtz wait on an ID/EX result or on a load in writeback
    jr_wait = (s.idex_wb_dest != '0 && s.idex_wb_dest == rs) ||
              (s.memwb_wb_dest != '0 && s.memwb_wb_dest == rs &&
               s.memwb_is_load && s.memwb_word_byte_half);

    stall = 1'b0;
    if (op == OP_RTYPE) begin
      if (reads_both_funct(fn))  stall = ld_rs || ld_rt;
      else if (shift_funct(fn))  stall = ld_rt;
      else if (fn == FN_JR)      stall = jr_wait;
    end else if (op == OP_BEQ || op == OP_BNE) begin
      stall = br_wait;
    end else if (op == OP_BGTZ) begin
      stall = jr_wait;
    end else if (store_op(op)) begin
      stall = ld_rs || ld_rt;
    end else if (op != OP_LUI && op != OP_J && op != OP_JAL) begin
      // unlisted I/J opcodes still check rs
      stall = ld_rs;
    end

    // operands actually read by the execute-stage instruction
    rd_rs = s.idex_is_rtype ? reads_both_funct(s.idex_code) : imm_reads_rs(s.idex_code);
    rd_rt = s.idex_is_rtype ? (reads_both_funct(s.idex_code) || shift_funct(s.idex_code))
                            : store_op(s.idex_code);

    em_rs = s.exmem_wb_dest != '0 && s.exmem_wb_dest == s.idex_rs;
    em_rt = s.exmem_wb_dest != '0 && s.exmem_wb_dest == s.idex_rt;
    mw_rs = s.memwb_wb_dest != '0 && s.memwb_wb_dest == s.idex_rs && !em_rs;
    mw_rt = s.memwb_wb_dest != '0 && s.memwb_wb_dest == s.idex_rt && !em_rt;

    v.stall_now    = stall;
    v.fwd_exmem_rs = !stall && rd_rs && em_rs;
    v.fwd_memwb_rs = !stall && rd_rs && mw_rs;
    v.fwd_exmem_rt = !stall && rd_rt && em_rt;
    v.fwd_memwb_rt = !stall && rd_rt && mw_rt;
    // branch compare forwards are not gated by the stall
    v.branch_fwd_rs = (op == OP_BEQ || op == OP_BNE || op == OP_BGTZ ||
                       (op == OP_RTYPE && fn == FN_JR)) &&
                      s.exmem_wb_dest != '0 && s.exmem_wb_dest == rs;
    v.branch_fwd_rt = (op == OP_BEQ || op == OP_BNE) &&
                      s.exmem_wb_dest != '0 && s.exmem_wb_dest == rt;
    return v;
  endfunction

  function automatic int field_err(string field, logic want, logic got);
    if (want !== got) begin
      $display("%0t: %s expected %0b got %0b", $time, field, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin : watch
    hfu_verdict_t want, got;
    int errs;
    if (!rst) begin
      if (snap.valid && snap.ready)
        expected_verdicts.push_back(predict_verdict(snap.data));
      if (verdict.valid && verdict.ready) begin
        got = verdict.data;
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result %b with no request outstanding", $time, got);
          n_fail++;
        end else begin
          want = expected_verdicts.pop_front();
          errs = field_err("stall_now", want.stall_now, got.stall_now) +
                 field_err("fwd_exmem_rs", want.fwd_exmem_rs, got.fwd_exmem_rs) +
                 field_err("fwd_memwb_rs", want.fwd_memwb_rs, got.fwd_memwb_rs) +
                 field_err("fwd_exmem_rt", want.fwd_exmem_rt, got.fwd_exmem_rt) +
                 field_err("fwd_memwb_rt", want.fwd_memwb_rt, got.fwd_memwb_rt) +
                 field_err("branch_fwd_rs", want.branch_fwd_rs, got.branch_fwd_rs) +
                 field_err("branch_fwd_rt", want.branch_fwd_rt, got.branch_fwd_rt);
          if (errs != 0) n_fail++;
          n_checked++;
          if (want.stall_now) n_stall++;
          if (want.fwd_exmem_rs || want.fwd_memwb_rs || want.fwd_exmem_rt ||
              want.fwd_memwb_rt) n_fwd++;
        end
      end
      n_pending = expected_verdicts.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for pipeline_hazard_forward_unit
// Sends directed pipeline snapshots (load-use, branch, jr/bgtz, register zero,
// priority and gating cases), then bursts of random snapshots built around a
// small register pool so that hazards and forwards are frequent. The result
// side stalls on a rotating pattern. Checking is done in hfu_verdict_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import hfu_pkg::*;

  localparam code_t UNLISTED_CODE = 6'h3f;
  localparam int    RANDOM_ITEMS  = 1150;

  logic clk;
  logic rst;
  int   fail_count, pending, checked, stalls_seen, forwards_seen;
  int   sent;

  hfu_snap_if    snap_ch();
  hfu_verdict_if verdict_ch();

  pipeline_hazard_forward_unit dut (
    .clk     (clk),
    .rst     (rst),
    .snap    (snap_ch),
    .verdict (verdict_ch)
  );

  hfu_verdict_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .snap          (snap_ch),
    .verdict       (verdict_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked),
    .stalls_seen   (stalls_seen),
    .forwards_seen (forwards_seen)
  );

  code_t op_pool[24] = '{OP_RTYPE, OP_RTYPE, OP_RTYPE, OP_RTYPE, OP_J, OP_JAL, OP_BEQ,
                         OP_BNE, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI,
                         OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB,
                         OP_SH, OP_SW};
  code_t fn_pool[16] = '{FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_JR, FN_MULT, FN_MULTU, FN_ADD,
                         FN_ADDU, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_ALU28, FN_SLT};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Result side: rotating stall pattern
  initial begin : rx_pattern
    int unsigned tick;
    tick = 0;
    verdict_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      case (tick[10:9])
        2'd0: verdict_ch.ready <= 1'b1;
        2'd1: verdict_ch.ready <= $urandom_range(0, 3) != 0;
        2'd2: verdict_ch.ready <= tick[2:0] != 3'd0;
        default: verdict_ch.ready <= tick[4:0] >= 5'd12;
      endcase
    end
  end

  // Mostly small register numbers so that matches are common
  function automatic reg_num_t pick_reg();
    if ($urandom_range(0, 9) < 7) return reg_num_t'($urandom_range(0, 3));
    return reg_num_t'($urandom);
  endfunction

  function automatic hfu_snap_t random_snap();
    hfu_snap_t   s;
    code_t       op;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    s = raw[$bits(hfu_snap_t)-1:0];
    if ($urandom_range(0, 6) != 0) begin
      op = op_pool[$urandom_range(0, 23)];
      s.decode_instr = {op, pick_reg(), pick_reg(), s.decode_instr[15:6],
                        fn_pool[$urandom_range(0, 15)]};
      s.idex_load_dest = pick_reg();
      s.idex_wb_dest   = pick_reg();
      s.idex_code      = s.idex_is_rtype ? fn_pool[$urandom_range(0, 15)]
                                         : op_pool[$urandom_range(0, 23)];
      s.idex_rs        = pick_reg();
      s.idex_rt        = pick_reg();
      s.exmem_wb_dest  = pick_reg();
      s.memwb_wb_dest  = pick_reg();
    end
    return s;
  endfunction

  function automatic hfu_snap_t snap_of(code_t op, reg_num_t rs, reg_num_t rt, code_t fn,
                                        reg_num_t ld, reg_num_t exd, logic rtype,
                                        code_t code, reg_num_t ers, reg_num_t ert,
                                        reg_num_t emd, reg_num_t mwd, logic wbh,
                                        logic mload);
    hfu_snap_t s;
    s.decode_instr         = {op, rs, rt, 10'd0, fn};
    s.idex_load_dest       = ld;
    s.idex_wb_dest         = exd;
    s.idex_is_rtype        = rtype;
    s.idex_code            = code;
    s.idex_rs              = ers;
    s.idex_rt              = ert;
    s.exmem_wb_dest        = emd;
    s.memwb_wb_dest        = mwd;
    s.memwb_word_byte_half = wbh;
    s.memwb_is_load        = mload;
    return s;
  endfunction

  // Hold the request until it is taken; returns on the accepting edge
  task automatic send(hfu_snap_t s);
    snap_ch.valid <= 1'b1;
    snap_ch.data  <= s;
    @(negedge clk);
    while (!snap_ch.ready) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  task automatic pause(int cycles);
    snap_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sender waits until every outstanding result is back
  task automatic drain();
    snap_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int burst;
    sent = 0;
    rst           <= 1'b1;
    snap_ch.valid <= 1'b0;
    snap_ch.data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // field extremes
    send('0);
    send('1);
    // R-type load-use; forwards suppressed by the stall
    send(snap_of(OP_RTYPE, 3, 4, FN_ADD, 3, 0, 1, FN_ADD, 5, 6, 5, 6, 0, 0));
    send(snap_of(OP_RTYPE, 3, 4, FN_SUB, 4, 0, 1, FN_ADD, 5, 6, 5, 6, 0, 0));
    // shift reads rt only
    send(snap_of(OP_RTYPE, 3, 4, FN_SLL, 3, 0, 1, FN_ADD, 5, 6, 5, 6, 0, 0));
    send(snap_of(OP_RTYPE, 3, 4, FN_SRA, 4, 0, 1, FN_ADD, 5, 6, 5, 6, 0, 0));
    // jr: execute match, writeback load, writeback non-load
    send(snap_of(OP_RTYPE, 9, 0, FN_JR, 0, 9, 0, OP_ADDI, 0, 0, 9, 0, 0, 0));
    send(snap_of(OP_RTYPE, 9, 0, FN_JR, 0, 0, 0, OP_ADDI, 0, 0, 0, 9, 1, 1));
    send(snap_of(OP_RTYPE, 9, 0, FN_JR, 0, 0, 0, OP_ADDI, 0, 0, 9, 9, 1, 0));
    // beq/bne hazards and branch compare forwards
    send(snap_of(OP_BEQ, 10, 11, FN_SLL, 0, 11, 0, OP_LW, 0, 0, 0, 0, 0, 0));
    send(snap_of(OP_BNE, 10, 11, FN_SLL, 0, 0, 0, OP_LW, 0, 0, 0, 10, 1, 0));
    send(snap_of(OP_BNE, 12, 12, FN_SLL, 0, 0, 0, OP_LW, 0, 0, 12, 0, 0, 0));
    // bgtz waits on a writeback load; none without memwb_word_byte_half
    send(snap_of(OP_BGTZ, 13, 0, FN_SLL, 0, 0, 0, OP_LW, 0, 0, 0, 13, 1, 1));
    send(snap_of(OP_BGTZ, 13, 0, FN_SLL, 0, 0, 0, OP_LW, 0, 0, 13, 13, 0, 1));
    // store, immediate, lui, j, jal
    send(snap_of(OP_SW, 14, 15, FN_SLL, 15, 0, 0, OP_LW, 0, 0, 0, 0, 0, 0));
    send(snap_of(OP_ADDI, 16, 17, FN_SLL, 16, 0, 0, OP_LW, 0, 0, 0, 0, 0, 0));
    send(snap_of(OP_ADDI, 16, 17, FN_SLL, 17, 0, 0, OP_LW, 0, 0, 0, 0, 0, 0));
    send(snap_of(OP_LUI, 18, 0, FN_SLL, 18, 0, 0, OP_LW, 0, 0, 0, 0, 0, 0));
    send(snap_of(OP_J, 19, 0, FN_SLL, 19, 0, 0, OP_LW, 0, 0, 0, 0, 0, 0));
    send(snap_of(OP_JAL, 19, 0, FN_SLL, 19, 0, 0, OP_LW, 0, 0, 0, 0, 0, 0));
    // unlisted opcode checks rs; unlisted funct never stalls
    send(snap_of(UNLISTED_CODE, 20, 0, FN_SLL, 20, 0, 0, OP_LW, 0, 0, 0, 0, 0, 0));
    send(snap_of(OP_RTYPE, 20, 21, UNLISTED_CODE, 20, 0, 1, FN_OR, 5, 6, 5, 6, 0, 0));
    // register zero never matches
    send(snap_of(OP_RTYPE, 0, 0, FN_ADD, 0, 0, 1, FN_ADD, 0, 0, 0, 0, 1, 1));
    // both stages match: EX/MEM wins
    send(snap_of(OP_RTYPE, 1, 2, FN_ADD, 0, 0, 1, FN_ADD, 7, 7, 7, 7, 1, 1));
    // execute-side store, shift and unlisted code
    send(snap_of(OP_RTYPE, 1, 2, FN_ADD, 0, 0, 0, OP_SW, 8, 9, 8, 9, 0, 0));
    send(snap_of(OP_RTYPE, 1, 2, FN_ADD, 0, 0, 1, FN_SRL, 8, 9, 8, 9, 0, 0));
    send(snap_of(OP_RTYPE, 1, 2, FN_ADD, 0, 0, 0, UNLISTED_CODE, 8, 9, 8, 9, 0, 0));
    drain();

    // random bursts, with a full drain now and then
    while (sent < RANDOM_ITEMS + 27) begin
      burst = $urandom_range(1, 48);
      repeat (burst) send(random_snap());
      if ($urandom_range(0, 5) == 0) drain();
      else if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
    end

    drain();
    repeat (4) @(posedge clk);

    $display("Sent %0d snapshots; %0d results checked, %0d stalled, %0d with execute forwards.",
             sent, checked, stalls_seen, forwards_seen);
    $display("Sender ran in random bursts; the result side cycled four stall patterns.");
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
